// File: rtl/sbc_pkg.sv
`default_nettype none

package sbc_pkg;

    // port width of every coordinate field
    localparam int FIELD_W        = 32;
    // significant coordinate bits by default
    localparam int COORD_BITS_DEF = 32;

    // queue depths (powers of two)
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // axis codes
    localparam int AX_X = 0;
    localparam int AX_Y = 1;

    // operand slots per axis, handed from front to back
    localparam int OP_A_LO = 0;  // low bound on the other axis minus start
    localparam int OP_A_HI = 1;  // high bound on the other axis minus start
    localparam int OP_T_LO = 2;  // low wall minus start on this axis
    localparam int OP_T_HI = 3;  // high wall minus start on this axis
    localparam int OP_DA   = 4;  // step along this axis, made positive
    localparam int OP_DB   = 5;  // step along the other axis, same sign flip
    localparam int NUM_OPS = 6;

    // product slots per axis
    localparam int PR_LO_DA = 0;
    localparam int PR_HI_DA = 1;
    localparam int PR_TLO_DB = 2;
    localparam int PR_THI_DB = 3;
    localparam int NUM_PR    = 4;

    // classification of one item, decided in the front
    typedef struct packed {
        logic       all_in;   // segment extent lies within the box
        logic       outside;  // segment extent is disjoint from the box
        logic [3:0] wall_ok;  // wall worth testing, index axis*2 + side
    } t_flags;

endpackage

`default_nettype wire

// File: rtl/sbc_fifo.sv
`default_nettype none

module sbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    output logic                            o_full,
    input  wire logic                       i_pop,
    output logic [WIDTH-1:0]                o_data,
    output logic                            o_empty,
    output logic [$clog2(DEPTH):0]          o_count
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count, n_count;
    logic             do_push;
    logic             do_pop;

    // handshake
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sbc_front.sv
`default_nettype none

module sbc_front
    import sbc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic [FIELD_W-1:0]                 i_start_x,
    input  wire logic [FIELD_W-1:0]                 i_start_y,
    input  wire logic [FIELD_W-1:0]                 i_end_x,
    input  wire logic [FIELD_W-1:0]                 i_end_y,
    input  wire logic [FIELD_W-1:0]                 i_box_low_x,
    input  wire logic [FIELD_W-1:0]                 i_box_low_y,
    input  wire logic [FIELD_W-1:0]                 i_box_high_x,
    input  wire logic [FIELD_W-1:0]                 i_box_high_y,
    output t_flags                                  o_flags,
    output logic [1:0][NUM_OPS-1:0][COORD_BITS:0]   o_ops
);

    localparam int W = COORD_BITS;

    logic signed [W-1:0] p0 [2];
    logic signed [W-1:0] p1 [2];
    logic signed [W-1:0] lo [2];
    logic signed [W-1:0] hi [2];
    logic [1:0]          in_ax;
    logic [1:0]          out_ax;

    // low coordinate bits as two's complement values
    assign p0[AX_X] = $signed(i_start_x[W-1:0]);
    assign p0[AX_Y] = $signed(i_start_y[W-1:0]);
    assign p1[AX_X] = $signed(i_end_x[W-1:0]);
    assign p1[AX_Y] = $signed(i_end_y[W-1:0]);
    assign lo[AX_X] = $signed(i_box_low_x[W-1:0]);
    assign lo[AX_Y] = $signed(i_box_low_y[W-1:0]);
    assign hi[AX_X] = $signed(i_box_high_x[W-1:0]);
    assign hi[AX_Y] = $signed(i_box_high_y[W-1:0]);

    // per axis: extent tests, wall pruning and operand differences
    always_comb begin
        logic signed [W:0] fwd_a;
        logic signed [W:0] rev_a;
        logic signed [W:0] fwd_b;
        logic signed [W:0] rev_b;
        logic              flip;
        logic              parallel;
        logic              lo_cut;
        logic              hi_cut;
        int                ot;
        for (int ax = 0; ax < 2; ax++) begin
            ot = 1 - ax;
            in_ax[ax]  = (p0[ax] >= lo[ax]) && (p1[ax] >= lo[ax]) &&
                         (p0[ax] <= hi[ax]) && (p1[ax] <= hi[ax]);
            out_ax[ax] = ((p0[ax] > hi[ax]) && (p1[ax] > hi[ax])) ||
                         ((p0[ax] < lo[ax]) && (p1[ax] < lo[ax]));

            // both directions computed side by side, picked by order
            fwd_a = (W+1)'(p1[ax]) - (W+1)'(p0[ax]);
            rev_a = (W+1)'(p0[ax]) - (W+1)'(p1[ax]);
            fwd_b = (W+1)'(p1[ot]) - (W+1)'(p0[ot]);
            rev_b = (W+1)'(p0[ot]) - (W+1)'(p1[ot]);
            flip     = p1[ax] < p0[ax];
            parallel = p1[ax] == p0[ax];

            // wall crossed unless both endpoints sit strictly on one side
            lo_cut = !(((p0[ax] < lo[ax]) && (p1[ax] < lo[ax])) ||
                       ((p0[ax] > lo[ax]) && (p1[ax] > lo[ax])));
            hi_cut = !(((p0[ax] < hi[ax]) && (p1[ax] < hi[ax])) ||
                       ((p0[ax] > hi[ax]) && (p1[ax] > hi[ax])));
            o_flags.wall_ok[ax*2]     = !parallel && lo_cut;
            o_flags.wall_ok[ax*2 + 1] = !parallel && hi_cut;

            o_ops[ax][OP_A_LO] = (W+1)'(lo[ot]) - (W+1)'(p0[ot]);
            o_ops[ax][OP_A_HI] = (W+1)'(hi[ot]) - (W+1)'(p0[ot]);
            o_ops[ax][OP_T_LO] = (W+1)'(lo[ax]) - (W+1)'(p0[ax]);
            o_ops[ax][OP_T_HI] = (W+1)'(hi[ax]) - (W+1)'(p0[ax]);
            o_ops[ax][OP_DA]   = flip ? rev_a : fwd_a;
            o_ops[ax][OP_DB]   = flip ? rev_b : fwd_b;
        end
        o_flags.all_in  = &in_ax;
        o_flags.outside = |out_ax;
    end

endmodule

`default_nettype wire

// File: rtl/sbc_back.sv
`default_nettype none

module sbc_back
    import sbc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_job_valid,
    input  wire t_flags                             i_flags,
    input  wire logic [1:0][NUM_OPS-1:0][COORD_BITS:0] i_ops,
    output logic                                    o_job_pop,
    input  wire logic                               pop,
    output logic                                    empty,
    output logic                                    o_touches
);

    localparam int W   = COORD_BITS;
    localparam int PW  = 2*W + 2;
    localparam int OAW = $clog2(OUT_DEPTH);
    localparam int CW  = OAW + 2;

    logic                           r_s1_v;
    t_flags                         r_flags;
    logic [1:0][NUM_PR-1:0][PW-1:0] r_prod;
    logic [1:0][NUM_PR-1:0][PW-1:0] n_prod;
    logic [OAW:0]                   out_count;
    logic                           out_full;
    logic                           touch;
    logic [3:0]                     hit;

    // take a job only if the result queue has room for it and the one in flight
    assign o_job_pop = i_job_valid &&
                       ((CW'(out_count) + CW'(r_s1_v)) < CW'(OUT_DEPTH));

    // cross products, one stage
    always_comb begin
        for (int ax = 0; ax < 2; ax++) begin
            n_prod[ax][PR_LO_DA]  = $signed(i_ops[ax][OP_A_LO]) * $signed(i_ops[ax][OP_DA]);
            n_prod[ax][PR_HI_DA]  = $signed(i_ops[ax][OP_A_HI]) * $signed(i_ops[ax][OP_DA]);
            n_prod[ax][PR_TLO_DB] = $signed(i_ops[ax][OP_T_LO]) * $signed(i_ops[ax][OP_DB]);
            n_prod[ax][PR_THI_DB] = $signed(i_ops[ax][OP_T_HI]) * $signed(i_ops[ax][OP_DB]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= o_job_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_flags <= i_flags;
            r_prod  <= n_prod;
        end
    end

    // hit coordinate within the box range on the other axis, bounds included
    always_comb begin
        logic signed [PW-1:0] tp;
        for (int ax = 0; ax < 2; ax++) begin
            for (int sd = 0; sd < 2; sd++) begin
                tp = $signed(r_prod[ax][PR_TLO_DB + sd]);
                hit[ax*2 + sd] = r_flags.wall_ok[ax*2 + sd] &&
                                 ($signed(r_prod[ax][PR_LO_DA]) <= tp) &&
                                 (tp <= $signed(r_prod[ax][PR_HI_DA]));
            end
        end
        touch = r_flags.all_in || (!r_flags.outside && (|hit));
    end

    // result queue toward the receiver
    sbc_fifo #(
        .WIDTH (1),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_v),
        .i_data  (touch),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_touches),
        .o_empty (empty),
        .o_count (out_count)
    );

endmodule

`default_nettype wire

// File: rtl/segment_box_crossing_test.sv
// Segment versus axis-aligned box crossing test.
// Input side is a queue: present one segment (start, end) and one box
// (low corner, high corner) with push; the word is taken on a clock edge
// where push is high and full is low. Coordinates use the low COORD_BITS
// bits of each 32-bit port as two's complement.
// Result side is a queue too: while empty is low, o_touches carries the
// oldest answer (1 when the segment touches the box or lies inside it);
// pop on a cycle with empty low takes it.
// One word is taken every cycle while full stays low. On its way to a result,
// the front classifies the word and computes its differences on the
// way into a 4-entry job queue, the back forms eight cross products in one
// registered stage and compares them on the way into a 4-entry result queue.
// When the receiver stops popping, the result queue fills, the back stops
// taking jobs, the job queue fills and full rises; nothing is dropped.
// Reset (synchronous, active low) empties both queues and the product stage.
`default_nettype none

module segment_box_crossing_test
    import sbc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [FIELD_W-1:0] i_start_x,
    input  wire logic [FIELD_W-1:0] i_start_y,
    input  wire logic [FIELD_W-1:0] i_end_x,
    input  wire logic [FIELD_W-1:0] i_end_y,
    input  wire logic [FIELD_W-1:0] i_box_low_x,
    input  wire logic [FIELD_W-1:0] i_box_low_y,
    input  wire logic [FIELD_W-1:0] i_box_high_x,
    input  wire logic [FIELD_W-1:0] i_box_high_y,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    o_touches
);

    localparam int OPS_W = 2 * NUM_OPS * (COORD_BITS + 1);
    localparam int JOB_W = $bits(t_flags) + OPS_W;

    t_flags                                  f_flags;
    logic [1:0][NUM_OPS-1:0][COORD_BITS:0]   f_ops;
    t_flags                                  b_flags;
    logic [1:0][NUM_OPS-1:0][COORD_BITS:0]   b_ops;
    logic [JOB_W-1:0]                        job_in;
    logic [JOB_W-1:0]                        job_out;
    logic                                    job_empty;
    logic                                    job_pop;

    // front: classify and difference
    sbc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_box_low_x  (i_box_low_x),
        .i_box_low_y  (i_box_low_y),
        .i_box_high_x (i_box_high_x),
        .i_box_high_y (i_box_high_y),
        .o_flags      (f_flags),
        .o_ops        (f_ops)
    );

    assign job_in = {f_flags, f_ops};

    // job queue between front and back
    sbc_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (MID_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty),
        .o_count ()
    );

    assign b_flags = t_flags'(job_out[JOB_W-1 -: $bits(t_flags)]);
    assign b_ops   = job_out[OPS_W-1:0];

    // back: products, compare, result queue
    sbc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!job_empty),
        .i_flags     (b_flags),
        .i_ops       (b_ops),
        .o_job_pop   (job_pop),
        .pop         (pop),
        .empty       (empty),
        .o_touches   (o_touches)
    );

endmodule

`default_nettype wire

// File: tb/touch_checker.sv
module touch_checker
    import sbc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic               i_full,
    input  wire logic [FIELD_W-1:0] i_start_x,
    input  wire logic [FIELD_W-1:0] i_start_y,
    input  wire logic [FIELD_W-1:0] i_end_x,
    input  wire logic [FIELD_W-1:0] i_end_y,
    input  wire logic [FIELD_W-1:0] i_box_low_x,
    input  wire logic [FIELD_W-1:0] i_box_low_y,
    input  wire logic [FIELD_W-1:0] i_box_high_x,
    input  wire logic [FIELD_W-1:0] i_box_high_y,
    input  wire logic               i_empty,
    input  wire logic               i_pop,
    input  wire logic               i_touches,
    output int                      o_pending,
    output int                      o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // answers still owed by the block, oldest first
    bit touch_q [$];

    // exact segment/box touch test; 34-bit differences, 68-bit products
    function automatic bit seg_box_touch(
        input logic [FIELD_W-1:0] sx, sy, ex, ey, lx, ly, hx, hy
    );
        logic signed [33:0] p0 [2];
        logic signed [33:0] p1 [2];
        logic signed [33:0] lo [2];
        logic signed [33:0] hi [2];
        logic signed [33:0] emin [2];
        logic signed [33:0] emax [2];
        logic signed [33:0] da, db, wall, t;
        logic signed [67:0] lhs, rhs;
        int ot;
        p0[0] = $signed(sx);
        p0[1] = $signed(sy);
        p1[0] = $signed(ex);
        p1[1] = $signed(ey);
        lo[0] = $signed(lx);
        lo[1] = $signed(ly);
        hi[0] = $signed(hx);
        hi[1] = $signed(hy);
        for (int ax = 0; ax < 2; ax++) begin
            emin[ax] = (p0[ax] <= p1[ax]) ? p0[ax] : p1[ax];
            emax[ax] = (p0[ax] <= p1[ax]) ? p1[ax] : p0[ax];
        end
        // extent wholly inside or wholly apart
        if (emin[0] >= lo[0] && emax[0] <= hi[0] && emin[1] >= lo[1] && emax[1] <= hi[1])
            return 1'b1;
        if (emin[0] > hi[0] || emax[0] < lo[0] || emin[1] > hi[1] || emax[1] < lo[1])
            return 1'b0;
        // try each wall; hit coordinate checked by cross-multiplication
        for (int ax = 0; ax < 2; ax++) begin
            ot = 1 - ax;
            da = p1[ax] - p0[ax];
            db = p1[ot] - p0[ot];
            if (da == 0)
                continue;
            if (da < 0) begin
                da = -da;
                db = -db;
            end
            for (int side = 0; side < 2; side++) begin
                wall = side ? hi[ax] : lo[ax];
                if ((p0[ax] < wall && p1[ax] < wall) || (p0[ax] > wall && p1[ax] > wall))
                    continue;
                t = wall - p0[ax];
                lhs = (lo[ot] - p0[ot]) * da;
                rhs = t * db;
                if (lhs <= rhs) begin
                    lhs = t * db;
                    rhs = (hi[ot] - p0[ot]) * da;
                    if (lhs <= rhs)
                        return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    // predict on every accepted input word, compare every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_push && !i_full)
                touch_q.push_back(seg_box_touch(i_start_x, i_start_y, i_end_x, i_end_y,
                                                i_box_low_x, i_box_low_y,
                                                i_box_high_x, i_box_high_y));
            if (i_pop && !i_empty) begin
                if (touch_q.size() == 0) begin
                    $error("touches: result word with nothing expected, actual %0b",
                           i_touches);
                    o_fail_count = o_fail_count + 1;
                end else if (touch_q[0] !== i_touches) begin
                    $error("touches mismatch: expected %0b, actual %0b",
                           touch_q[0], i_touches);
                    o_fail_count = o_fail_count + 1;
                    void'(touch_q.pop_front());
                end else begin
                    void'(touch_q.pop_front());
                end
            end
            o_pending <= touch_q.size();
        end
    end

endmodule

// File: tb/segment_box_crossing_test_tb.sv
module segment_box_crossing_test_tb;
    import sbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_WORDS = 1880;
    localparam logic [FIELD_W-1:0] C_MIN = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] C_MAX = 32'h7FFF_FFFF;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [FIELD_W-1:0] i_start_x = '0;
    logic [FIELD_W-1:0] i_start_y = '0;
    logic [FIELD_W-1:0] i_end_x = '0;
    logic [FIELD_W-1:0] i_end_y = '0;
    logic [FIELD_W-1:0] i_box_low_x = '0;
    logic [FIELD_W-1:0] i_box_low_y = '0;
    logic [FIELD_W-1:0] i_box_high_x = '0;
    logic [FIELD_W-1:0] i_box_high_y = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic               o_touches;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int stall_left = 0;
    bit calm_sender = 1'b0;
    bit calm_receiver = 1'b0;

    segment_box_crossing_test DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_box_low_x (i_box_low_x),
        .i_box_low_y (i_box_low_y),
        .i_box_high_x(i_box_high_x),
        .i_box_high_y(i_box_high_y),
        .empty       (empty),
        .pop         (pop),
        .o_touches   (o_touches)
    );

    touch_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_box_low_x (i_box_low_x),
        .i_box_low_y (i_box_low_y),
        .i_box_high_x(i_box_high_x),
        .i_box_high_y(i_box_high_y),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_touches   (o_touches),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, mostly short, some long, calm stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            calm_receiver = !calm_receiver;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            pop <= 1'b0;
        end else if (calm_receiver) begin
            pop <= 1'b1;
        end else begin
            case ($urandom_range(0, 99)) inside
                [0:14]:  begin stall_left = $urandom_range(0, 2);   pop <= 1'b0; end
                [15:17]: begin stall_left = $urandom_range(10, 60); pop <= 1'b0; end
                default: pop <= 1'b1;
            endcase
        end
    end

    // idle cycles after a word on the input side
    function automatic int pick_gap();
        int r;
        if (calm_sender)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // present one word and hold it until it is taken
    task automatic send_word(input logic [FIELD_W-1:0] sx, sy, ex, ey, lx, ly, hx, hy);
        int gap;
        i_start_x    <= sx;
        i_start_y    <= sy;
        i_end_x      <= ex;
        i_end_y      <= ey;
        i_box_low_x  <= lx;
        i_box_low_y  <= ly;
        i_box_high_x <= hx;
        i_box_high_y <= hy;
        push         <= 1'b1;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending until every answer has come back
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [FIELD_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return '0;
            3:       return '1;
            4:       return 32'd1;
            default: return $urandom();
        endcase
    endfunction

    // coordinate near a box: often on a wall or one step past it
    function automatic int near_coord(int off, int span, int wlo, int whi);
        int r;
        r = $urandom_range(0, 15);
        if (r < 2)
            return wlo;
        if (r < 4)
            return whi;
        if (r == 4)
            return wlo - 1;
        if (r == 5)
            return whi + 1;
        return off - 2 * span + int'($urandom_range(0, 4 * span));
    endfunction

    // random word: noise, extreme values, or a segment around a box
    task automatic send_random_word();
        int kind, s, span, off_x, off_y, lx, ly, hx, hy, tmp;
        logic [FIELD_W-1:0] f [8];
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            for (int k = 0; k < 8; k++)
                f[k] = $urandom();
        end else if (kind < 25) begin
            for (int k = 0; k < 8; k++)
                f[k] = pick_extreme();
        end else begin
            s = $urandom_range(1, 28);
            span = 1 << s;
            off_x = int'($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
            off_y = int'($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
            lx = off_x - int'($urandom_range(0, span));
            hx = off_x + int'($urandom_range(0, span));
            ly = off_y - int'($urandom_range(0, span));
            hy = off_y + int'($urandom_range(0, span));
            // now and then an inverted box
            if ($urandom_range(0, 15) == 0) begin
                tmp = lx;
                lx = hx;
                hx = tmp;
            end
            if ($urandom_range(0, 15) == 0) begin
                tmp = ly;
                ly = hy;
                hy = tmp;
            end
            f[4] = lx;
            f[5] = ly;
            f[6] = hx;
            f[7] = hy;
            f[0] = near_coord(off_x, span, lx, hx);
            f[1] = near_coord(off_y, span, ly, hy);
            f[2] = near_coord(off_x, span, lx, hx);
            f[3] = near_coord(off_y, span, ly, hy);
            // point segments and axis-aligned segments
            case ($urandom_range(0, 19))
                0: begin f[2] = f[0]; f[3] = f[1]; end
                1: f[2] = f[0];
                2: f[3] = f[1];
                default: ;
            endcase
        end
        send_word(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]);
    endtask

    // stimulus and verdict
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // point inside, on a corner, outside
        send_word(5, 5, 5, 5, 0, 0, 10, 10);
        send_word(10, 0, 10, 0, 0, 0, 10, 10);
        send_word(11, 5, 11, 5, 0, 0, 10, 10);
        // wholly inside, wholly apart
        send_word(1, 2, 9, 8, 0, 0, 10, 10);
        send_word(20, 20, 30, 25, 0, 0, 10, 10);
        // diagonal through, extent overlaps but line misses, corner graze
        send_word(-5, -3, 15, 12, 0, 0, 10, 10);
        send_word(-10, 5, 5, 20, 0, 0, 10, 10);
        send_word(-5, 5, 5, 15, 0, 0, 10, 10);
        // horizontal and vertical crossings, segment along a wall
        send_word(-5, 5, 15, 5, 0, 0, 10, 10);
        send_word(0, -5, 0, 15, 0, 0, 10, 10);
        send_word(-5, 10, 15, 10, 0, 0, 10, 10);
        // end point resting on a wall
        send_word(10, 5, 20, 5, 0, 0, 10, 10);
        // near miss and exact touch at a corner
        send_word(7, 0, 0, 7, 0, 0, 3, 3);
        send_word(6, 0, 0, 6, 0, 0, 3, 3);
        // inverted box
        send_word(-5, 5, 15, 5, 10, 10, 0, 0);
        send_word(5, 5, 5, 5, 10, 10, 0, 0);
        // full-range coordinates
        send_word(C_MIN, C_MIN, C_MAX, C_MAX, -1, -1, 1, 1);
        send_word(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX);
        send_word(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX - 1, C_MIN, C_MAX, C_MIN + 1);
        send_word(C_MIN, C_MAX, C_MAX, C_MAX - 1, C_MAX - 2, C_MAX - 1, C_MAX, C_MAX);
        send_word('0, '0, '0, '0, '0, '0, '0, '0);
        send_word('1, '1, '1, '1, '1, '1, '1, '1);
        send_word(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        send_word(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 150 == 0)
                calm_sender = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_WORDS / 2)
                drain_results();
            send_random_word();
        end

        // wait out the last answers, then a few cycles for strays
        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: segment_box_crossing_test.f
rtl/sbc_pkg.sv
rtl/sbc_fifo.sv
rtl/sbc_front.sv
rtl/sbc_back.sv
rtl/segment_box_crossing_test.sv
tb/touch_checker.sv
tb/segment_box_crossing_test_tb.sv
